[sv/pwlm_pkg.sv]
// ----------------------------------------------------------------------------
// pwlm_pkg
// Shared types and constants of the piecewise-linear curve map: field widths,
// register indexes, reset curve and the sequencer states.
// ----------------------------------------------------------------------------
package pwlm_pkg;

	// Number of breakpoint registers and the most that may be in use.
	localparam int MAX_POINTS = 7;
	localparam int IDX_W      = 3;
	localparam int X_W        = 16;
	localparam int Y_W        = 16;
	localparam int PT_W       = X_W + Y_W;
	localparam int PROD_W     = X_W + Y_W;
	localparam int CNT_W      = $clog2(PROD_W);

	// Register indexes of the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_POINT_COUNT = 3'd0,
		REG_POINT_A     = 3'd1,
		REG_POINT_B     = 3'd2,
		REG_POINT_C     = 3'd3,
		REG_POINT_D     = 3'd4,
		REG_POINT_E     = 3'd5,
		REG_POINT_F     = 3'd6,
		REG_POINT_G     = 3'd7
	} cfg_reg_t;

	// Reset curve: x in the upper half, y in the lower half.
	localparam logic [IDX_W-1:0] COUNT_RESET = 3'd7;
	localparam logic [PT_W-1:0] POINT_RESET [MAX_POINTS] = '{
		32'd268435456, 32'd322109466, 32'd389218355, 32'd469762150,
		32'd496631962, 32'd563740877, 32'd711328051
	};

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FIRST = 8'b0000_0010,
		S_LAST  = 8'b0000_0100,
		S_SCAN  = 8'b0000_1000,
		S_MUL   = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_ADD   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

endpackage

[sv/piecewise_linear_curve_map_top.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_curve_map_top
// Maps an unsigned Q4.12 sample to an unsigned Q8.8 value through a curve of
// up to seven programmable breakpoints, with range and table-order flags.
// ----------------------------------------------------------------------------
// One sample is handled at a time. After a sample beat is accepted, the block
// checks the first and then the last used breakpoint, then scans the
// segments one per cycle, registers the offset product, divides it by the
// segment width with a bit-serial restoring divider, one quotient bit per
// cycle, adds the quotient to the segment start and loads the output
// register. An out-of-range, zero-width-segment or unmatched sample skips
// the multiply, divide and add steps. A new sample is taken once the result
// sits in the output register, even if it has not yet been taken.
// Configuration writes are taken every cycle and must only be issued while
// the block is idle.
module piecewise_linear_curve_map_top
	import pwlm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [PT_W-1:0]  cfg_data,
	// Sample channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [X_W-1:0]   sample_x,
	// Result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Y_W-1:0]   mapped_y,
	output logic             below_range,
	output logic             above_range,
	output logic             no_segment
);

	state_t              state_q;
	logic [IDX_W-1:0]    count_q;
	logic [PT_W-1:0]     points_q [MAX_POINTS];

	logic [X_W-1:0]      v_q;
	logic [IDX_W-1:0]    idx_q;
	logic [PT_W-1:0]     prev_q;
	logic [X_W-1:0]      off_q;
	logic [Y_W-1:0]      dy_q;
	logic [X_W-1:0]      dx_q;
	logic [Y_W-1:0]      y0_q;
	logic                neg_q;
	logic [PROD_W-1:0]   quo_q;
	logic [X_W-1:0]      rem_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [Y_W-1:0]      res_y_q;
	logic                res_below_q;
	logic                res_above_q;
	logic                res_miss_q;

	logic                out_valid_q;
	logic [Y_W-1:0]      out_y_q;
	logic                out_below_q;
	logic                out_above_q;
	logic                out_miss_q;

	logic [IDX_W-1:0]    n_used;
	logic [IDX_W-1:0]    last_idx;
	logic [PT_W-1:0]     rd_pt;
	logic [X_W-1:0]      rd_x;
	logic [Y_W-1:0]      rd_y;
	logic [X_W-1:0]      prev_x;
	logic [Y_W-1:0]      prev_y;
	logic                seg_hit;
	logic [PROD_W-1:0]   prod;
	logic [X_W:0]        rem_sh;
	logic [X_W:0]        rem_diff;
	logic                take;
	logic                out_free;

	// Clamp the point count to the usable range.
	always_comb begin
		if (count_q < 3'd2) begin
			n_used = 3'd2;
		end else if (count_q > IDX_W'(MAX_POINTS)) begin
			n_used = IDX_W'(MAX_POINTS);
		end else begin
			n_used = count_q;
		end
		last_idx = n_used - 3'd1;
	end

	// Single read port on the breakpoint registers.
	assign rd_pt  = points_q[idx_q];
	assign rd_x   = rd_pt[PT_W-1:Y_W];
	assign rd_y   = rd_pt[Y_W-1:0];
	assign prev_x = prev_q[PT_W-1:Y_W];
	assign prev_y = prev_q[Y_W-1:0];
	assign seg_hit = (v_q >= prev_x) && (v_q <= rd_x);

	// Offset times height; the multiplier is registered before the divider.
	assign prod = PROD_W'(off_q) * PROD_W'(dy_q);

	// One restoring divide step.
	assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
	assign rem_diff = rem_sh - {1'b0, dx_q};
	assign take     = rem_sh >= {1'b0, dx_q};

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			for (int k = 0; k < MAX_POINTS; k++) begin
				points_q[k] <= POINT_RESET[k];
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_POINT_COUNT) begin
				count_q <= cfg_data[IDX_W-1:0];
			end else begin
				points_q[cfg_index - 3'd1] <= cfg_data;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					if (v_q <= rd_x) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (v_q >= rd_x) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (seg_hit) begin
						state_q <= (rd_x == prev_x) ? S_DONE : S_MUL;
					end else if (idx_q == last_idx) begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					v_q         <= sample_x;
					idx_q       <= '0;
					res_y_q     <= '0;
					res_below_q <= 1'b0;
					res_above_q <= 1'b0;
					res_miss_q  <= 1'b0;
				end
			end
			S_FIRST: begin
				prev_q <= rd_pt;
				idx_q  <= last_idx;
				if (v_q <= rd_x) begin
					res_below_q <= 1'b1;
				end
			end
			S_LAST: begin
				idx_q <= 3'd1;
				if (v_q >= rd_x) begin
					res_above_q <= 1'b1;
					res_y_q     <= rd_y;
				end
			end
			S_SCAN: begin
				if (seg_hit) begin
					off_q   <= v_q - prev_x;
					dx_q    <= rd_x - prev_x;
					y0_q    <= prev_y;
					res_y_q <= prev_y;
					neg_q   <= rd_y < prev_y;
					dy_q    <= (rd_y < prev_y) ? (prev_y - rd_y) : (rd_y - prev_y);
				end else begin
					prev_q <= rd_pt;
					idx_q  <= idx_q + 3'd1;
					if (idx_q == last_idx) begin
						res_miss_q <= 1'b1;
					end
				end
			end
			S_MUL: begin
				quo_q <= prod;
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= take ? rem_diff[X_W-1:0] : rem_sh[X_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], take};
				cnt_q <= cnt_q + 1'b1;
			end
			S_ADD: begin
				// The quotient never exceeds the segment height.
				res_y_q <= neg_q ? (y0_q - quo_q[Y_W-1:0]) : (y0_q + quo_q[Y_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_y_q     <= res_y_q;
			out_below_q <= res_below_q;
			out_above_q <= res_above_q;
			out_miss_q  <= res_miss_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign mapped_y    = out_y_q;
	assign below_range = out_below_q;
	assign above_range = out_above_q;
	assign no_segment  = out_miss_q;

endmodule

[sv/pwlm_checker.sv]
// ----------------------------------------------------------------------------
// pwlm_checker
// Port-level checks of the curve map, bound to the top level.
// ----------------------------------------------------------------------------
module pwlm_checker
	import pwlm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [Y_W-1:0]   mapped_y,
	input logic             below_range,
	input logic             above_range,
	input logic             no_segment
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped_y)
			&& $stable(below_range) && $stable(above_range) && $stable(no_segment))
		else $error("result beat changed while stalled");

	// At most one flag is set on a result.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({below_range, above_range, no_segment}))
		else $error("more than one range flag set");

	// Below-range and unmatched results carry zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (below_range || no_segment) |-> mapped_y == '0)
		else $error("nonzero value with below or no-segment flag");

	// The block works on one sample at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while busy");

endmodule

bind piecewise_linear_curve_map_top pwlm_checker u_pwlm_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the piecewise-linear curve map against a predictor that works out
// each mapped value and range flag from its own copy of the breakpoint table.
// Directed curves cover the range ends, count clamping, extreme points,
// overlapping ends and unsorted tables. Random curves, mostly sorted, are then
// swept with samples aimed at segment interiors and breakpoints. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import pwlm_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 100;

	// One predicted result, tagged with the sample that caused it.
	typedef struct {
		logic [X_W-1:0] sample;
		logic [Y_W-1:0] y;
		logic           below;
		logic           above;
		logic           miss;
	} curve_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [PT_W-1:0]  cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [X_W-1:0]   sample_x;
	logic             out_valid;
	logic             out_ready;
	logic [Y_W-1:0]   mapped_y;
	logic             below_range;
	logic             above_range;
	logic             no_segment;

	// Shadow copy of the curve registers.
	logic [IDX_W-1:0] curve_count;
	logic [PT_W-1:0]  curve_pts [MAX_POINTS];

	curve_result_t pending_q [$];
	int            err_count;
	int            idle_cycles;
	bit            stall_on;

	piecewise_linear_curve_map_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_x    (sample_x),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mapped_y    (mapped_y),
		.below_range (below_range),
		.above_range (above_range),
		.no_segment  (no_segment)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predict the mapped value and flags of one sample under the shadow curve.
	function automatic curve_result_t map_sample(input logic [X_W-1:0] v);
		curve_result_t     r;
		int                used;
		logic [X_W-1:0]    x0, x1, dx, off;
		logic [Y_W-1:0]    y0, y1, dy;
		logic [PROD_W-1:0] prod, quot;
		bit                found;
		r.sample = v;
		r.y      = '0;
		r.below  = 1'b0;
		r.above  = 1'b0;
		r.miss   = 1'b0;
		used = int'(curve_count);
		if (used < 2) used = 2;
		if (used > MAX_POINTS) used = MAX_POINTS;
		if (v <= curve_pts[0][PT_W-1:Y_W]) begin
			r.below = 1'b1;
		end else if (v >= curve_pts[used-1][PT_W-1:Y_W]) begin
			r.above = 1'b1;
			r.y     = curve_pts[used-1][Y_W-1:0];
		end else begin
			found = 1'b0;
			for (int i = 0; i < used - 1; i++) begin
				x0 = curve_pts[i][PT_W-1:Y_W];
				x1 = curve_pts[i+1][PT_W-1:Y_W];
				if (!found && v >= x0 && v <= x1) begin
					found = 1'b1;
					y0 = curve_pts[i][Y_W-1:0];
					y1 = curve_pts[i+1][Y_W-1:0];
					dx = x1 - x0;
					off = v - x0;
					if (dx == '0) begin
						r.y = y0;
					end else begin
						// Divide the magnitude of the rise, then step from the start.
						dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
						prod = PROD_W'(off) * PROD_W'(dy);
						quot = prod / PROD_W'(dx);
						r.y = (y1 >= y0) ? y0 + quot[Y_W-1:0] : y0 - quot[Y_W-1:0];
					end
				end
			end
			if (!found) r.miss = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Write one register; valid stays up unless this is the last beat.
	task automatic cfg_write(input cfg_reg_t idx, input logic [PT_W-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_POINT_COUNT)
			curve_count = data[IDX_W-1:0];
		else
			curve_pts[int'(idx) - int'(REG_POINT_A)] = data;
		if (last) cfg_valid <= 1'b0;
	endtask

	// Load the count and all seven breakpoints.
	task automatic program_curve(input logic [IDX_W-1:0] count,
				     input logic [PT_W-1:0] pts [MAX_POINTS]);
		cfg_write(REG_POINT_COUNT, PT_W'(count), 1'b0);
		for (int k = 0; k < MAX_POINTS; k++)
			cfg_write(cfg_reg_t'(int'(REG_POINT_A) + k), pts[k], k == MAX_POINTS - 1);
	endtask

	// Send one sample beat and record its prediction once accepted.
	task automatic send_sample(input logic [X_W-1:0] x);
		int gap;
		gap = stall_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_x <= x;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_q.push_back(map_sample(x));
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// Compare one accepted result beat with the oldest prediction.
	task automatic check_result();
		curve_result_t want;
		if (pending_q.size() == 0) begin
			report_mismatch($sformatf("result beat y=%h with no sample pending", mapped_y));
			return;
		end
		want = pending_q.pop_front();
		if (mapped_y !== want.y)
			report_mismatch($sformatf("x=%h mapped_y %h, expected %h",
				want.sample, mapped_y, want.y));
		if (below_range !== want.below)
			report_mismatch($sformatf("x=%h below_range %b, expected %b",
				want.sample, below_range, want.below));
		if (above_range !== want.above)
			report_mismatch($sformatf("x=%h above_range %b, expected %b",
				want.sample, above_range, want.above));
		if (no_segment !== want.miss)
			report_mismatch($sformatf("x=%h no_segment %b, expected %b",
				want.sample, no_segment, want.miss));
	endtask

	// Result side: random stall before each beat, then check it.
	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		forever begin
			gap = stall_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result();
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset curve: range ends, exact breakpoints and interior points.
	task automatic test_reset_curve();
		logic [X_W-1:0] samples [7];
		samples = '{16'h0000, 16'h1000, 16'h1001, 16'h1333, 16'h2000, 16'h2A66, 16'hFFFF};
		foreach (samples[k]) send_sample(samples[k]);
	endtask

	// Counts of zero and one fall back to two points.
	task automatic test_count_clamp();
		drain();
		cfg_write(REG_POINT_COUNT, PT_W'(0), 1'b1);
		send_sample(16'h1200);
		send_sample(16'h2000);
		drain();
		cfg_write(REG_POINT_COUNT, PT_W'(1), 1'b1);
		send_sample(16'h1100);
		send_sample(16'h1333);
	endtask

	// Points at the field extremes, falling and rising steep segments.
	task automatic test_extreme_points();
		logic [PT_W-1:0] pts [MAX_POINTS];
		logic [X_W-1:0]  samples [6];
		pts = '{{16'h0000, 16'hFFFF}, {16'h1000, 16'h0000}, {16'h1000, 16'h8000},
			{16'h8000, 16'hFFFF}, {16'hC000, 16'h0001}, {16'hFFFE, 16'hFFFF},
			{16'hFFFF, 16'h0000}};
		samples = '{16'h0000, 16'h0800, 16'h4000, 16'hA000, 16'hFFFE, 16'hFFFF};
		drain();
		program_curve(3'd7, pts);
		foreach (samples[k]) send_sample(samples[k]);
	endtask

	// First x above the last used x: below wins at or under the first x.
	task automatic test_both_ends();
		logic [PT_W-1:0] pts [MAX_POINTS];
		pts = '{{16'h8000, 16'h1234}, {16'h9000, 16'h5555}, {16'h4000, 16'hABCD},
			{16'h0000, 16'h0000}, {16'h0000, 16'h0000}, {16'h0000, 16'h0000},
			{16'h0000, 16'h0000}};
		drain();
		program_curve(3'd3, pts);
		send_sample(16'h4000);
		send_sample(16'h8000);
		send_sample(16'h8001);
	endtask

	// Unsorted table with a zero-width segment in it.
	task automatic test_unsorted();
		logic [PT_W-1:0] pts [MAX_POINTS];
		pts = '{{16'h2000, 16'h0100}, {16'h1000, 16'h0200}, {16'h6000, 16'h0050},
			{16'h3000, 16'h0400}, {16'h3000, 16'h0900}, {16'h7000, 16'h0010},
			{16'h5000, 16'h0777}};
		drain();
		program_curve(3'd6, pts);
		send_sample(16'h2800);
		send_sample(16'h5000);
		send_sample(16'h6FFF);
	endtask

	// Random curves, mostly sorted, swept with aimed and free samples.
	task automatic test_random_curves();
		logic [PT_W-1:0]  pts [MAX_POINTS];
		logic [X_W-1:0]   xs [MAX_POINTS];
		logic [X_W-1:0]   tmp, lo, hi, x;
		logic [IDX_W-1:0] count;
		int               kind, pick, used, j;
		for (int phase = 0; phase < PHASES; phase++) begin
			kind = $urandom_range(0, 9);
			foreach (xs[k]) xs[k] = X_W'($urandom_range(0, 16'hFFFF));
			// Insertion sort unless this curve is meant to be unsorted.
			if (kind < 9) begin
				for (int k = 1; k < MAX_POINTS; k++) begin
					tmp = xs[k];
					j = k - 1;
					while (j >= 0 && xs[j] > tmp) begin
						xs[j+1] = xs[j];
						j--;
					end
					xs[j+1] = tmp;
				end
			end
			// Some sorted curves get a repeated x, making a zero-width segment.
			if (kind == 8) xs[$urandom_range(1, MAX_POINTS - 1)] = xs[0];
			if (kind == 7) begin
				j = $urandom_range(1, MAX_POINTS - 1);
				xs[j] = xs[j-1];
			end
			foreach (pts[k]) pts[k] = {xs[k], 16'($urandom_range(0, 16'hFFFF))};
			case (phase)
				0:       count = 3'd7;
				1:       count = 3'd2;
				2:       count = 3'd0;
				default: count = 3'($urandom_range(0, 7));
			endcase
			stall_on = (phase % 4) != 3;
			drain();
			program_curve(count, pts);
			used = (count < 3'd2) ? 2 : int'(count);
			lo = xs[0];
			hi = xs[used-1];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					x = X_W'($urandom_range(lo, hi));
				else if (pick < 8)
					x = xs[$urandom_range(0, used - 1)] + X_W'($urandom_range(0, 4)) - 16'd2;
				else
					x = X_W'($urandom_range(0, 16'hFFFF));
				send_sample(x);
			end
		end
		stall_on = 1'b1;
	endtask

	// Main sequence.
	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_POINT_COUNT;
		cfg_data    = '0;
		in_valid    = 1'b0;
		sample_x    = '0;
		err_count   = 0;
		idle_cycles = 0;
		stall_on    = 1'b1;
		curve_count = COUNT_RESET;
		foreach (curve_pts[k]) curve_pts[k] = POINT_RESET[k];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_curve();
		test_count_clamp();
		test_extreme_points();
		test_both_ends();
		test_unsorted();
		test_random_curves();

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[piecewise_linear_curve_map_top.f]
sv/pwlm_pkg.sv
sv/piecewise_linear_curve_map_top.sv
sv/pwlm_checker.sv
tb/testbench.sv
